>>> rtl/core/fpcd_pkg.sv
package fpcd_pkg;

  // Fixed code: longest code word, size of the table
  localparam int unsigned MaxCodeLen = 7;
  localparam int unsigned NumCodes   = 15;
  localparam int unsigned ByteBits   = 8;

  localparam int unsigned PendW  = MaxCodeLen - 1;        // partial code bits kept
  localparam int unsigned LenW   = $clog2(MaxCodeLen + 1); // code length 0..7
  localparam int unsigned SkipW  = 4;                     // header byte counter
  localparam int unsigned SymW   = 8;
  localparam int unsigned SlotW  = $clog2(ByteBits);      // result slot index
  localparam int unsigned CntW   = $clog2(ByteBits + 1);  // result count 0..8

  typedef struct packed {
    logic [LenW-1:0]       len;
    logic [MaxCodeLen-1:0] code;
    logic [SymW-1:0]       ch;
  } code_entry_t;

  typedef struct packed {
    logic            hit;
    logic [SymW-1:0] ch;
  } code_match_t;

  // Code words, first received bit in the MSB of the used length
  localparam code_entry_t CODE_TABLE [NumCodes] = '{
    '{len: 3'd1, code: 7'd1,  ch: 8'h69},  // i
    '{len: 3'd2, code: 7'd0,  ch: 8'h2e},  // .
    '{len: 3'd4, code: 7'd7,  ch: 8'h6c},  // l
    '{len: 3'd5, code: 7'd9,  ch: 8'h31},  // 1
    '{len: 3'd6, code: 7'd22, ch: 8'h30},  // 0
    '{len: 3'd6, code: 7'd27, ch: 8'h32},  // 2
    '{len: 3'd6, code: 7'd24, ch: 8'h33},  // 3
    '{len: 3'd6, code: 7'd23, ch: 8'h34},  // 4
    '{len: 3'd6, code: 7'd21, ch: 8'h35},  // 5
    '{len: 3'd6, code: 7'd25, ch: 8'h36},  // 6
    '{len: 3'd6, code: 7'd20, ch: 8'h37},  // 7
    '{len: 3'd6, code: 7'd17, ch: 8'h38},  // 8
    '{len: 3'd6, code: 7'd26, ch: 8'h39},  // 9
    '{len: 3'd7, code: 7'd33, ch: 8'h20},  // space
    '{len: 3'd7, code: 7'd32, ch: 8'h49}   // I
  };

  localparam logic [SkipW-1:0] HeaderBytesRst = 4'd4;

  // Parallel compare against every table entry
  function automatic code_match_t fpcd_match(input logic [LenW-1:0]       len,
                                             input logic [MaxCodeLen-1:0] code);
    code_match_t m;
    m = '0;
    for (int k = 0; k < NumCodes; k++) begin
      if (CODE_TABLE[k].len == len && CODE_TABLE[k].code == code) begin
        m.hit = 1'b1;
        m.ch  = CODE_TABLE[k].ch;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/core/fixed_prefix_code_decoder_core.sv
// A byte accepted into the input register is decoded from it and moves into the
//   result buffer once that is free; its result beats are offered from there.
// Throughput: one byte per cycle while the output is ready and a byte gives at
//   most one result beat, else set by the single output beat per cycle (up to 8).
// Reset: asynchronous, active low; clears partial code, header counter and all
//   buffered beats, and loads header_bytes with 4.
module fixed_prefix_code_decoder_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: header_bytes
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [fpcd_pkg::SkipW-1:0] cfg_data_i,
  // encoded byte stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] in_byte
  input  logic                      s_axis_tuser,   // [0] frame_start
  input  logic                      s_axis_tlast,   // frame_end
  // decoded symbols
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] symbol
  output logic                      m_axis_tuser,   // [0] error
  output logic                      m_axis_tlast    // last beat for this byte
);
  import fpcd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register, always ready; write only while idle (unchecked)
  // ---------------------------------------------------------------------------
  logic [SkipW-1:0] header_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderBytesRst;
    end else if (cfg_valid_i) begin
      header_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                in_vld_q;
  logic [ByteBits-1:0] in_byte_q;
  logic                in_start_q;
  logic                in_end_q;
  logic                load;      // input beat moves into the result buffer
  logic                buf_free;

  assign s_axis_tready = !in_vld_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
      in_end_q   <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode: header bytes are skipped, other bytes take eight one-bit steps of the
  // prefix matcher, each a narrow compare against the 15-entry table.
  // ---------------------------------------------------------------------------
  logic [PendW-1:0]      pend_bits_q, pend_bits_d;
  logic [LenW-1:0]       pend_cnt_q,  pend_cnt_d;
  logic [SkipW-1:0]      skip_q,      skip_d;

  logic [PendW-1:0]      pb;
  logic [LenW-1:0]       pc;
  logic [SkipW-1:0]      sk;
  logic [LenW-1:0]       step_len;
  logic [MaxCodeLen-1:0] step_code;
  code_match_t           step_m;
  logic [CntW-1:0]       n_sym;
  logic [SymW-1:0]       new_sym [ByteBits];
  logic                  new_err;
  logic [CntW-1:0]       new_cnt;

  always_comb begin
    // a new frame drops any carried state before the byte is looked at
    pb        = in_start_q ? '0 : pend_bits_q;
    pc        = in_start_q ? '0 : pend_cnt_q;
    sk        = in_start_q ? '0 : skip_q;
    n_sym     = '0;
    new_err   = 1'b0;
    step_len  = '0;
    step_code = '0;
    step_m    = '0;
    for (int s = 0; s < ByteBits; s++) begin
      new_sym[s] = '0;
    end

    if (sk < header_q) begin
      sk = sk + SkipW'(1);
    end else begin
      for (int b = 0; b < ByteBits; b++) begin
        step_len  = pc + LenW'(1);
        step_code = {1'b0, pb} << 1 | MaxCodeLen'(in_byte_q[b]);
        step_m    = fpcd_match(step_len, step_code);
        if (step_m.hit) begin
          new_sym[n_sym[SlotW-1:0]] = step_m.ch;
          n_sym = n_sym + CntW'(1);
          pb    = '0;
          pc    = '0;
        end else if (step_len >= LenW'(MaxCodeLen)) begin
          // cannot happen with a complete code: drop the bits
          pb = '0;
          pc = '0;
        end else begin
          pb = step_code[PendW-1:0];
          pc = step_len;
        end
      end
    end

    // frame end: leftover bits give an error beat with symbol zero
    if (in_end_q) begin
      new_err = (pc != '0);
      pb      = '0;
      pc      = '0;
      sk      = '0;
    end

    new_cnt     = n_sym + CntW'(new_err);
    pend_bits_d = pb;
    pend_cnt_d  = pc;
    skip_d      = sk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      skip_q      <= '0;
    end else if (load) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      skip_q      <= skip_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: up to 8 beats per byte, drained one per cycle while ready.
  // The error beat, when present, is the last beat of the byte.
  // ---------------------------------------------------------------------------
  logic [SymW-1:0]  res_sym_q [ByteBits];
  logic             res_err_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SlotW-1:0] rd_q,  rd_d;
  logic             pop;

  assign pop      = m_axis_tvalid && m_axis_tready;
  assign buf_free = (cnt_q == '0) || (cnt_q == CntW'(1) && m_axis_tready);
  assign load     = in_vld_q && buf_free;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load) begin
      cnt_d = new_cnt;
      rd_d  = '0;
    end else if (pop) begin
      cnt_d = cnt_q - CntW'(1);
      rd_d  = rd_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_sym_q <= new_sym;
      res_err_q <= new_err;
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tlast  = (cnt_q == CntW'(1));
  assign m_axis_tdata  = res_sym_q[rd_q];
  assign m_axis_tuser  = res_err_q && m_axis_tlast;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ByteBits))
    else $error("result count above eight");

  a_pend_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q < LenW'(MaxCodeLen))
    else $error("partial code longer than six bits");

  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("error beat not final or symbol nonzero");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !load |-> !s_axis_tready)
    else $error("input register overwritten while held");

  a_load_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && m_axis_tvalid |-> m_axis_tready && m_axis_tlast)
    else $error("buffer reloaded before its beats were taken");

endmodule

>>> tb/sv/tb_fixed_prefix_code_decoder_core.sv
`timescale 1ns / 100ps

module tb_fixed_prefix_code_decoder_core;
  import fpcd_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 8;     // byte in flight that gives no beat
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseBeats  = 51;    // bytes sent per random phase

  // typed expectation count; this value hands the row to the predictor
  localparam logic signed [4:0] Predicted = -5'sd1;

  // one output beat
  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            err;
    logic            last;
  } sym_beat_t;

  // one directed row: n_sym beats of sym, then an optional error beat
  typedef struct packed {
    logic [7:0]       data;
    logic             sof;
    logic             eof;
    logic signed [4:0] n_sym;
    logic [SymW-1:0]  sym;
    logic             err_tail;
  } stim_row_t;

  localparam int unsigned NumRows = 24;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // header bytes after reset (4 of them): extremes and alternating bit patterns
    '{8'hFF, 1'b1, 1'b0, 5'sd0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 5'sd0, 8'h00, 1'b0},
    '{8'hA5, 1'b0, 1'b0, 5'sd0, 8'h00, 1'b0},
    '{8'h5A, 1'b0, 1'b0, 5'sd0, 8'h00, 1'b0},
    // all ones: eight 1-bit codes; all zeros: four 2-bit codes
    '{8'hFF, 1'b0, 1'b0, 5'sd8, "i",   1'b0},
    '{8'h00, 1'b0, 1'b0, 5'sd4, ".",   1'b0},
    // frame end with "01" left over -> error beat
    '{8'h80, 1'b0, 1'b1, 5'sd3, ".",   1'b1},
    // new frame without start flag: header skipped again
    '{8'h11, 1'b0, 1'b0, 5'sd0, 8'h00, 1'b0},
    '{8'h22, 1'b0, 1'b0, 5'sd0, 8'h00, 1'b0},
    '{8'h44, 1'b0, 1'b0, 5'sd0, 8'h00, 1'b0},
    '{8'h88, 1'b0, 1'b0, 5'sd0, 8'h00, 1'b0},
    // every code word once, 80 bits, codes straddle byte borders
    '{8'h71, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'hA9, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'hD9, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'h86, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'hAE, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'h9A, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'h8A, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'h68, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'h09, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'h05, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    // leaves one bit pending, then a start mid-frame must drop it:
    // the ending header byte must give no error beat
    '{8'h40, 1'b0, 1'b0, Predicted, 8'h00, 1'b0},
    '{8'h00, 1'b1, 1'b0, 5'sd0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 5'sd0, 8'h00, 1'b0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [SkipW-1:0] cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             s_axis_tuser;
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  // decoder state as the predictor sees it
  logic [PendW-1:0] code_bits;
  logic [LenW-1:0]  code_len;
  logic [SkipW-1:0] hdr_seen;
  logic [SkipW-1:0] hdr_bytes;

  sym_beat_t   pending_symbols [$];
  sym_beat_t   want_beat;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned stall_left;
  int          frame_left;
  logic        calm;          // no idling on either side

  fixed_prefix_code_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] frame_start
    .s_axis_tlast  (s_axis_tlast),   // frame_end
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] symbol
    .m_axis_tuser  (m_axis_tuser),   // [0] error
    .m_axis_tlast  (m_axis_tlast)    // last beat for this byte
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Code word -> character, first received bit is the MSB of the word.
  // Returns {hit, char}.
  function automatic logic [SymW:0] code_lookup(input logic [LenW-1:0]       len,
                                                input logic [MaxCodeLen-1:0] word);
    case ({len, word})
      {3'd1, 7'd1}:  return {1'b1, "i"};
      {3'd2, 7'd0}:  return {1'b1, "."};
      {3'd4, 7'd7}:  return {1'b1, "l"};
      {3'd5, 7'd9}:  return {1'b1, "1"};
      {3'd6, 7'd22}: return {1'b1, "0"};
      {3'd6, 7'd27}: return {1'b1, "2"};
      {3'd6, 7'd24}: return {1'b1, "3"};
      {3'd6, 7'd23}: return {1'b1, "4"};
      {3'd6, 7'd21}: return {1'b1, "5"};
      {3'd6, 7'd25}: return {1'b1, "6"};
      {3'd6, 7'd20}: return {1'b1, "7"};
      {3'd6, 7'd17}: return {1'b1, "8"};
      {3'd6, 7'd26}: return {1'b1, "9"};
      {3'd7, 7'd33}: return {1'b1, " "};
      {3'd7, 7'd32}: return {1'b1, "I"};
      default:       return '0;
    endcase
  endfunction

  // Append one expected beat at the tail of the queue.
  function automatic void add_beat(input logic [SymW-1:0] sym, input logic err);
    sym_beat_t beat;
    beat = '{sym: sym, err: err, last: 1'b0};
    pending_symbols.insert(pending_symbols.size(), beat);
  endfunction

  // Decode one accepted byte, queue its beats, return how many.
  function automatic int decode_byte(input logic [7:0] data, input logic sof,
                                     input logic eof);
    int              n;
    logic [LenW-1:0] len;
    logic [MaxCodeLen-1:0] word;
    logic [SymW:0]   hit_ch;
    n = 0;
    if (sof) begin
      code_bits = '0;
      code_len  = '0;
      hdr_seen  = '0;
    end
    if (hdr_seen < hdr_bytes) begin
      hdr_seen = hdr_seen + 1'b1;
    end else begin
      for (int b = 0; b < ByteBits; b++) begin
        len    = code_len + 1'b1;
        word   = {code_bits, data[b]};
        hit_ch = code_lookup(len, word);
        if (hit_ch[SymW]) begin
          add_beat(hit_ch[SymW-1:0], 1'b0);
          n++;
          code_bits = '0;
          code_len  = '0;
        end else if (len >= MaxCodeLen) begin
          // cannot happen with a complete code; bits dropped
          code_bits = '0;
          code_len  = '0;
        end else begin
          code_bits = word[PendW-1:0];
          code_len  = len;
        end
      end
    end
    if (eof) begin
      if (code_len != 0) begin
        add_beat('0, 1'b1);
        n++;
      end
      code_bits = '0;
      code_len  = '0;
      hdr_seen  = '0;
    end
    if (n > 0) pending_symbols[pending_symbols.size()-1].last = 1'b1;
    return n;
  endfunction

  // Offer one byte, with an optional idle burst first; predict at acceptance.
  task automatic push_byte(input logic [7:0] data, input logic sof, input logic eof,
                           output int n);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= sof;
    s_axis_tlast  <= eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n = decode_byte(data, sof, eof);
  endtask

  // Stop sending and let every expected beat come out, plus the byte latency.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [SkipW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    hdr_bytes = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed frames (start, header, payload, end) with random bytes;
  // some frames lack a start or an end, some are cut short, and stray flags
  // show up now and then. Frames run on across phase borders.
  task automatic run_phase(input int unsigned target);
    int unsigned got;
    int          n;
    logic        sof;
    logic        eof;
    logic [7:0]  data;
    got = 0;
    while (got < target) begin
      sof = 1'b0;
      if (frame_left <= 0) begin
        if ($urandom_range(0, 9) == 0) frame_left = $urandom_range(1, 16);
        else frame_left = hdr_bytes + $urandom_range(1, 6);
        sof = ($urandom_range(0, 7) != 0);
      end
      eof = (frame_left == 1) && ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 19) == 0) sof = 1'b1;
      if ($urandom_range(0, 19) == 0) eof = 1'b1;
      case ($urandom_range(0, 9))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom_range(0, 255));
      endcase
      push_byte(data, sof, eof, n);
      frame_left--;
      got++;
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endfunction

  // Output side: random stall bursts, none once calm.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every output beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_symbols.size() == 0) begin
        fail_cnt++;
        $display("%0t: beat with nothing expected, expected none, actual sym %02h err %0b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want_beat = pending_symbols.pop_front();
        check_field("symbol", want_beat.sym, m_axis_tdata);
        check_field("error", {7'd0, want_beat.err}, {7'd0, m_axis_tuser});
        check_field("last", {7'd0, want_beat.last}, {7'd0, m_axis_tlast});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int        n;
    stim_row_t row;
    logic [SkipW-1:0] phase_hdr [NumPhases];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    cycle_cnt     = 0;
    fail_cnt      = 0;
    frame_left    = 0;
    calm          = 1'b0;
    code_bits     = '0;
    code_len      = '0;
    hdr_seen      = '0;
    hdr_bytes     = HeaderBytesRst;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, header_bytes at its reset value
    for (int i = 0; i < NumRows; i++) begin
      row = DirectedRows[i];
      push_byte(row.data, row.sof, row.eof, n);
      if (row.n_sym != Predicted) begin
        // predictor still tracks state; the typed beats replace its output
        repeat (n) void'(pending_symbols.pop_back());
        for (int k = 0; k < row.n_sym; k++)
          add_beat(row.sym, 1'b0);
        if (row.err_tail) add_beat('0, 1'b1);
        if (row.n_sym > 0 || row.err_tail)
          pending_symbols[pending_symbols.size()-1].last = 1'b1;
      end
    end
    drain();

    // random phases; header changes land mid-frame as well
    phase_hdr[0] = 4'd0;
    phase_hdr[1] = 4'd15;
    phase_hdr[2] = 4'd1;
    phase_hdr[3] = 4'($urandom_range(2, 14));
    phase_hdr[4] = 4'd0;
    phase_hdr[5] = 4'd3;
    for (int p = 0; p < NumPhases; p++) begin
      calm = (p == NumPhases - 1);
      write_header(phase_hdr[p]);
      run_phase(PhaseBeats);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
